[design/axis_telegram_parser_macros.svh]
// assertion helpers for the telegram parser
// every macro samples on clk and is switched off while rst_n is low
`ifndef AXIS_TELEGRAM_PARSER_MACROS_SVH
`define AXIS_TELEGRAM_PARSER_MACROS_SVH

// same-cycle implication
`define ATP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atp check failed");

// next-cycle implication
`define ATP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atp check failed");

`endif

[design/atp_pkg.sv]
// shared types and constants for the telegram parser
// used by the front parser, the command queue, the axis back end and the top level
`default_nettype none

package atp_pkg;

  localparam int BYTE_W       = 8;
  localparam int AXIS_W       = 3;
  localparam int VAL_W        = 16;
  localparam int OFFS_W       = 14;
  localparam int SUM_W        = 14;
  localparam int RSUM_W       = 16;
  localparam int PAY_AW       = 4;   // payload address, covers up to 8 axes
  localparam int OUT_TDATA_W  = 24;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;

  localparam int CHANNELS_DEF = 6;
  localparam int QDEPTH_LOG   = 2;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd150;
  localparam logic [BYTE_W-1:0] FOOTER_RST = 8'd141;
  localparam logic [OFFS_W-1:0] OFFSET_RST = 14'd8192;

  // register indexes
  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_FOOTER = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // command kinds
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PAY_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

[design/atp_front.sv]
// byte-level telegram parser: header search, data, checksum and footer check
// depends on atp_pkg; pushes store and emit commands into the command queue
`default_nettype none

module atp_front import atp_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,
  input  wire logic [BYTE_W-1:0] header_byte,
  input  wire logic [BYTE_W-1:0] footer_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  localparam int DATA_LEN = 2 * CHANNELS;
  localparam int CNT_W    = $clog2(DATA_LEN);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(DATA_LEN - 1);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_CHK_HI = 3'd2;
  localparam logic [2:0] PH_CHK_LO = 3'd3;
  localparam logic [2:0] PH_FOOTER = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  run_sum_r, run_sum_nxt;
  logic [RSUM_W-1:0] rx_sum_r, rx_sum_nxt;
  logic              beat;

  assign in_tready = !q_full;
  assign beat      = in_tvalid && in_tready;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    run_sum_nxt = run_sum_r;
    rx_sum_nxt  = rx_sum_r;
    q_push      = 1'b0;
    q_cmd.kind  = CMD_STORE;
    q_cmd.addr  = PAY_AW'(count_r);
    q_cmd.data  = in_tdata;
    if (beat) begin
      unique case (phase_r)
        PH_DATA: begin
          q_push      = 1'b1;
          run_sum_nxt = run_sum_r + SUM_W'(in_tdata);
          if (count_r == LAST_IDX) begin
            count_nxt  = '0;
            rx_sum_nxt = '0;
            phase_nxt  = PH_CHK_HI;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        PH_CHK_HI: begin
          rx_sum_nxt = {1'b0, in_tdata, 7'b0};
          phase_nxt  = PH_CHK_LO;
        end
        PH_CHK_LO: begin
          rx_sum_nxt = rx_sum_r + {8'b0, in_tdata};
          phase_nxt  = PH_FOOTER;
        end
        PH_FOOTER: begin
          if (in_tdata == footer_byte && rx_sum_r == {2'b0, run_sum_r}) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_EMIT;
          end
          run_sum_nxt = '0;
          phase_nxt   = PH_HEADER;
        end
        default: begin
          // header search, unused codes behave the same
          if (in_tdata == header_byte) begin
            run_sum_nxt = SUM_W'(in_tdata);
            count_nxt   = '0;
            phase_nxt   = PH_DATA;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      count_r   <= '0;
      run_sum_r <= '0;
      rx_sum_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      run_sum_r <= run_sum_nxt;
      rx_sum_r  <= rx_sum_nxt;
    end
  end

endmodule

`default_nettype wire

[design/atp_cmdq.sv]
// short command queue between the parser front and the axis back end
// depends on atp_pkg for the command struct
`default_nettype none

module atp_cmdq import atp_pkg::*; #(
  parameter int DEPTH_LOG = QDEPTH_LOG
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int DEPTH = 2 ** DEPTH_LOG;

  cmd_t                 q_r [DEPTH];
  logic [DEPTH_LOG-1:0] wptr_r, wptr_nxt;
  logic [DEPTH_LOG-1:0] rptr_r, rptr_nxt;
  logic [DEPTH_LOG:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (DEPTH_LOG + 1)'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + DEPTH_LOG'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + DEPTH_LOG'(1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (DEPTH_LOG + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (DEPTH_LOG + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[design/atp_back.sv]
// axis back end: payload ram, axis value arithmetic and the output register
// depends on atp_pkg and the assertion macros header
`default_nettype none
`include "axis_telegram_parser_macros.svh"

module atp_back import atp_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [OFFS_W-1:0]      axis_offset,
  input  wire logic                   q_empty,
  input  wire cmd_t                   q_head,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int DATA_LEN = 2 * CHANNELS;
  localparam int ADDR_W   = $clog2(DATA_LEN);
  localparam logic [AXIS_W-1:0] CH_LAST = AXIS_W'(CHANNELS - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RDHI = 2'd1;
  localparam logic [1:0] B_RDLO = 2'd2;
  localparam logic [1:0] B_CALC = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [AXIS_W-1:0] ch_r, ch_nxt;
  logic [BYTE_W-1:0] hi_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] pay_mem [DATA_LEN];
  logic [PAY_AW-1:0] rd_addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic              out_load;
  logic [VAL_W-1:0]  axis_val;
  logic              out_valid_r;
  logic [AXIS_W-1:0] out_index_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_last_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == CMD_EMIT) begin
            ch_nxt    = '0;
            state_nxt = B_RDHI;
          end
        end
      end
      B_RDHI: state_nxt = B_RDLO;
      B_RDLO: state_nxt = B_CALC;
      B_CALC: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (ch_r == CH_LAST) begin
            state_nxt = B_IDLE;
          end else begin
            ch_nxt    = ch_r + AXIS_W'(1);
            state_nxt = B_RDHI;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign mem_we = q_pop && (q_head.kind == CMD_STORE);

  // high byte at the even address, low byte at the odd one; held through calc
  assign rd_addr_full = {ch_r, (state_r != B_RDHI)};
  assign rd_addr      = rd_addr_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[q_head.addr[ADDR_W-1:0]] <= q_head.data;
    end
    rd_data_r <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == B_RDLO) begin
      hi_r <= rd_data_r;
    end
  end

  assign axis_val = {1'b0, hi_r, 7'b0} + {8'b0, rd_data_r} - {2'b0, axis_offset};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= ch_r;
      out_value_r <= axis_val;
      out_last_r  <= (ch_r == CH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - VAL_W - AXIS_W){1'b0}}, out_value_r, out_index_r};
  assign out_tlast  = out_last_r;

  `ATP_ASSERT_SAME(a_last_on_final_axis, out_valid_r && out_last_r, out_index_r == CH_LAST)
  `ATP_ASSERT_SAME(a_axis_in_range, state_r != B_IDLE, ch_r <= CH_LAST)
  `ATP_ASSERT_NEXT(a_idle_after_last, out_load && (ch_r == CH_LAST), state_r == B_IDLE)
  `ATP_ASSERT_SAME(a_no_load_over_pending, out_valid_r && !out_tready, !out_load)

endmodule

`default_nettype wire

[design/axis_telegram_parser.sv]
// Telegram parser for a six-axis serial input device. Bytes arrive one per beat on the in_
// stream; a header byte opens a telegram of 2*CHANNELS data bytes, a two-byte checksum
// ((high << 7) + low, compared with the 14-bit sum of header and data) and a footer byte.
// A good telegram yields CHANNELS beats on the out_ stream, axis 0 first, tlast on the final
// axis; a bad one yields nothing. The front parser takes one byte per cycle as long as its
// 4-entry command queue has room. The back end drains the queue one command per cycle while
// idle and, after a good footer, pops the emit command and then works through each axis in
// turn (a read of the high byte, a read of the low byte and an arithmetic step), stalled by
// the output; bytes that arrive meanwhile wait in the queue. No reset sweep is needed.
// depends on atp_pkg, atp_front, atp_cmdq and atp_back
`default_nettype none

module axis_telegram_parser import atp_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [BYTE_W-1:0]      in_tdata,    // [7:0] rx_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // [2:0] axis_index, [18:3] axis_value
  output logic                        out_tlast,   // last_axis
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_AW-1:0]      paddr,
  input  wire logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]           prdata,
  output logic                        pready
);

  logic [BYTE_W-1:0] header_r;
  logic [BYTE_W-1:0] footer_r;
  logic [OFFS_W-1:0] offset_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_cmd, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      footer_r <= FOOTER_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HEADER: header_r <= pwdata[BYTE_W-1:0];
        REG_FOOTER: footer_r <= pwdata[BYTE_W-1:0];
        REG_OFFSET: offset_r <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEADER: prdata = {{(CFG_DW - BYTE_W){1'b0}}, header_r};
      REG_FOOTER: prdata = {{(CFG_DW - BYTE_W){1'b0}}, footer_r};
      REG_OFFSET: prdata = {{(CFG_DW - OFFS_W){1'b0}}, offset_r};
      default:    prdata = '0;
    endcase
  end

  atp_front #(.CHANNELS(CHANNELS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .header_byte (header_r),
    .footer_byte (footer_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  atp_cmdq #(.DEPTH_LOG(QDEPTH_LOG)) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  atp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .axis_offset (offset_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire
